// ===== src/tcwpd_pkg.sv =====
`timescale 1ns / 1ps

package tcwpd_pkg;

    // fixed field widths
    localparam int TASK_W   = 16;
    localparam int CLASS_W  = 2;
    localparam int STATUS_W = 2;
    localparam int CREDIT_W = 8;

    // defaults for the top-level parameters
    localparam int QUEUE_DEPTH_DEF  = 16;
    localparam int TASK_ID_BITS_DEF = 16;

    // transaction kinds
    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    // class codes
    localparam logic [CLASS_W-1:0] CLS_LOW    = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_NORMAL = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_HIGH   = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_ENQUEUED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_GRANTED  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

    // credit limits and burst reset value
    localparam logic [CREDIT_W-1:0] CREDIT_MAX  = 8'd255;
    localparam logic [CREDIT_W-1:0] BURST_RESET = 8'd3;

endpackage

// ===== src/three_class_weighted_priority_dispatch_top.sv =====
`timescale 1ns / 1ps

// Three-class task dispatcher. Input channel (i_in_valid / o_in_stall) carries
// one transaction per item: kind 0 pushes i_task_id into the queue of class
// i_priority_req (0 low, 1 normal, 2 high), kind 1 asks for the next task.
// High is served ahead of a waiting normal task while the high-served credit
// is below the burst register; low only when high and normal are empty.
// Output channel (o_out_valid / i_out_stall) returns exactly one result per
// item. The config channel (i_cfg_valid / o_cfg_ready, always ready) writes
// the burst register; write it only while the block is idle.
// All three queues share one single-port RAM of 3*QUEUE_DEPTH words with a
// registered read; heads, counts and credit live in flops.
// An accepted transaction does the RAM write or the RAM read while its status
// is loaded into the staging register; the output register then takes it with
// the read data. Throughput is one item per cycle, set by the single RAM port,
// while the receiver does not stall. When it stalls, the output register holds,
// the staging register fills, and then o_in_stall rises until the output drains.
// Reset (synchronous, active low) empties all queues, clears the credit and
// loads the burst register with 3; RAM contents are not cleared.
module three_class_weighted_priority_dispatch_top #(
    parameter int QUEUE_DEPTH  = tcwpd_pkg::QUEUE_DEPTH_DEF,
    parameter int TASK_ID_BITS = tcwpd_pkg::TASK_ID_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_kind,
    input  logic [tcwpd_pkg::CLASS_W-1:0]   i_priority_req,
    input  logic [tcwpd_pkg::TASK_W-1:0]    i_task_id,
    // output channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [tcwpd_pkg::STATUS_W-1:0]  o_status,
    output logic [tcwpd_pkg::TASK_W-1:0]    o_granted_task,
    output logic [tcwpd_pkg::CLASS_W-1:0]   o_granted_class,
    output logic                            o_any_waiting,
    // config channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tcwpd_pkg::CREDIT_W-1:0]  i_cfg_high_burst
);

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int MEM_D  = 3 * QUEUE_DEPTH;
    localparam int ADDR_W = $clog2(MEM_D);
    localparam int ID_W   = TASK_ID_BITS;

    localparam logic [ADDR_W-1:0] BASE_LOW    = '0;
    localparam logic [ADDR_W-1:0] BASE_NORMAL = ADDR_W'(QUEUE_DEPTH);
    localparam logic [ADDR_W-1:0] BASE_HIGH   = ADDR_W'(2 * QUEUE_DEPTH);

    // queue storage
    logic [ID_W-1:0] r_mem [MEM_D];
    logic [ID_W-1:0] r_rd_data;

    // per-class heads and counts, credit and burst register
    logic [PTR_W-1:0] r_head  [3];
    logic [PTR_W-1:0] n_head  [3];
    logic [CNT_W-1:0] r_count [3];
    logic [CNT_W-1:0] n_count [3];
    logic [tcwpd_pkg::CREDIT_W-1:0] r_credit;
    logic [tcwpd_pkg::CREDIT_W-1:0] n_credit;
    logic [tcwpd_pkg::CREDIT_W-1:0] r_burst;

    // staging register
    logic                            r_a_valid;
    logic [tcwpd_pkg::STATUS_W-1:0]  r_a_status;
    logic [tcwpd_pkg::CLASS_W-1:0]   r_a_class;
    logic                            r_a_any;
    logic                            r_a_grant;

    // output register
    logic                            r_out_valid;
    logic [tcwpd_pkg::STATUS_W-1:0]  r_out_status;
    logic [tcwpd_pkg::TASK_W-1:0]    r_out_task;
    logic [tcwpd_pkg::CLASS_W-1:0]   r_out_class;
    logic                            r_out_any;

    // decision signals
    logic                            in_acc;
    logic                            a_move;
    logic                            push_en;
    logic                            pop_en;
    logic [tcwpd_pkg::CLASS_W-1:0]   op_cls;
    logic [tcwpd_pkg::STATUS_W-1:0]  step_status;
    logic                            step_any;
    logic                            mem_we;
    logic                            mem_re;
    logic [ADDR_W-1:0]               mem_addr;
    logic [ID_W-1:0]                 wr_id;

    function automatic logic [tcwpd_pkg::CLASS_W-1:0] CLASS_IDX(input int c);
        CLASS_IDX = tcwpd_pkg::CLASS_W'(c);
    endfunction

    // handshake
    assign a_move      = r_a_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_a_valid && !a_move;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign wr_id       = ID_W'(i_task_id);

    // scheduling decision for the offered item
    always_comb begin
        logic                 hi_ne;
        logic                 no_ne;
        logic                 lo_ne;
        logic [CNT_W-1:0]     sel_cnt;
        logic                 cls_ok;
        hi_ne       = r_count[tcwpd_pkg::CLS_HIGH] != '0;
        no_ne       = r_count[tcwpd_pkg::CLS_NORMAL] != '0;
        lo_ne       = r_count[tcwpd_pkg::CLS_LOW] != '0;
        push_en     = 1'b0;
        pop_en      = 1'b0;
        op_cls      = tcwpd_pkg::CLS_LOW;
        step_status = tcwpd_pkg::ST_EMPTY;
        sel_cnt     = '0;
        cls_ok      = 1'b1;
        unique case (i_priority_req)
            tcwpd_pkg::CLS_LOW:    sel_cnt = r_count[tcwpd_pkg::CLS_LOW];
            tcwpd_pkg::CLS_NORMAL: sel_cnt = r_count[tcwpd_pkg::CLS_NORMAL];
            tcwpd_pkg::CLS_HIGH:   sel_cnt = r_count[tcwpd_pkg::CLS_HIGH];
            default:               cls_ok  = 1'b0;
        endcase
        if (i_kind == tcwpd_pkg::KIND_ENQ) begin
            op_cls = i_priority_req;
            if (cls_ok && sel_cnt != CNT_W'(QUEUE_DEPTH)) begin
                push_en     = 1'b1;
                step_status = tcwpd_pkg::ST_ENQUEUED;
            end else begin
                step_status = tcwpd_pkg::ST_FULL;
            end
        end else if (!hi_ne && !no_ne) begin
            if (lo_ne) begin
                pop_en      = 1'b1;
                op_cls      = tcwpd_pkg::CLS_LOW;
                step_status = tcwpd_pkg::ST_GRANTED;
            end
        end else if (hi_ne && (!no_ne || r_credit < r_burst)) begin
            pop_en      = 1'b1;
            op_cls      = tcwpd_pkg::CLS_HIGH;
            step_status = tcwpd_pkg::ST_GRANTED;
        end else begin
            pop_en      = 1'b1;
            op_cls      = tcwpd_pkg::CLS_NORMAL;
            step_status = tcwpd_pkg::ST_GRANTED;
        end
    end

    // ram address: class base plus tail slot for push, head slot for pop
    always_comb begin
        logic [PTR_W-1:0]  head_sel;
        logic [CNT_W-1:0]  cnt_sel;
        logic [SUM_W-1:0]  tail_sum;
        logic [PTR_W-1:0]  slot;
        logic [ADDR_W-1:0] base;
        head_sel = r_head[tcwpd_pkg::CLS_LOW];
        cnt_sel  = r_count[tcwpd_pkg::CLS_LOW];
        base     = BASE_LOW;
        unique case (op_cls)
            tcwpd_pkg::CLS_NORMAL: begin
                head_sel = r_head[tcwpd_pkg::CLS_NORMAL];
                cnt_sel  = r_count[tcwpd_pkg::CLS_NORMAL];
                base     = BASE_NORMAL;
            end
            tcwpd_pkg::CLS_HIGH: begin
                head_sel = r_head[tcwpd_pkg::CLS_HIGH];
                cnt_sel  = r_count[tcwpd_pkg::CLS_HIGH];
                base     = BASE_HIGH;
            end
            default: begin
                head_sel = r_head[tcwpd_pkg::CLS_LOW];
                cnt_sel  = r_count[tcwpd_pkg::CLS_LOW];
                base     = BASE_LOW;
            end
        endcase
        tail_sum = SUM_W'(head_sel) + SUM_W'(cnt_sel);
        if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
            tail_sum = tail_sum - SUM_W'(QUEUE_DEPTH);
        end
        slot     = push_en ? PTR_W'(tail_sum) : head_sel;
        mem_addr = base + ADDR_W'(slot);
        mem_we   = in_acc && push_en;
        mem_re   = in_acc && pop_en;
    end

    // next heads, counts, credit and the any-waiting flag
    always_comb begin
        logic any_acc;
        any_acc = 1'b0;
        for (int c = 0; c < 3; c++) begin
            n_head[c]  = r_head[c];
            n_count[c] = r_count[c];
            if (push_en && op_cls == CLASS_IDX(c)) begin
                n_count[c] = r_count[c] + CNT_W'(1);
            end
            if (pop_en && op_cls == CLASS_IDX(c)) begin
                n_count[c] = r_count[c] - CNT_W'(1);
                n_head[c]  = (r_head[c] == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : r_head[c] + PTR_W'(1);
            end
            any_acc = any_acc || (n_count[c] != '0);
        end
        step_any = any_acc;
        n_credit = r_credit;
        if (pop_en && op_cls == tcwpd_pkg::CLS_HIGH) begin
            if (r_credit != tcwpd_pkg::CREDIT_MAX) begin
                n_credit = r_credit + 8'd1;
            end
        end else if (pop_en && op_cls == tcwpd_pkg::CLS_NORMAL) begin
            n_credit = (r_credit >= r_burst) ? r_credit - r_burst : '0;
        end
    end

    // queue ram, one access per cycle, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= wr_id;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_addr];
        end
    end

    // queue control state and burst register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < 3; c++) begin
                r_head[c]  <= '0;
                r_count[c] <= '0;
            end
            r_credit <= '0;
            r_burst  <= tcwpd_pkg::BURST_RESET;
        end else begin
            if (in_acc) begin
                for (int c = 0; c < 3; c++) begin
                    r_head[c]  <= n_head[c];
                    r_count[c] <= n_count[c];
                end
                r_credit <= n_credit;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_burst <= i_cfg_high_burst;
            end
        end
    end

    // staging register, loaded alongside the registered ram read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_acc) begin
            r_a_valid <= 1'b1;
        end else if (a_move) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_status <= step_status;
            r_a_class  <= pop_en ? op_cls : tcwpd_pkg::CLS_LOW;
            r_a_any    <= step_any;
            r_a_grant  <= pop_en;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (a_move) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move) begin
            r_out_status <= r_a_status;
            r_out_task   <= r_a_grant ? tcwpd_pkg::TASK_W'(r_rd_data) : '0;
            r_out_class  <= r_a_class;
            r_out_any    <= r_a_any;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_granted_task  = r_out_task;
    assign o_granted_class = r_out_class;
    assign o_any_waiting   = r_out_any;

endmodule

// ===== verif/tcwpd_dispatch_checker.sv =====
`timescale 1ns / 1ps

module tcwpd_dispatch_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input channel
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic                           i_kind,
    input  logic [tcwpd_pkg::CLASS_W-1:0]  i_priority_req,
    input  logic [tcwpd_pkg::TASK_W-1:0]   i_task_id,
    // output channel
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [tcwpd_pkg::STATUS_W-1:0] i_status,
    input  logic [tcwpd_pkg::TASK_W-1:0]   i_granted_task,
    input  logic [tcwpd_pkg::CLASS_W-1:0]  i_granted_class,
    input  logic                           i_any_waiting,
    // config channel
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [tcwpd_pkg::CREDIT_W-1:0] i_cfg_high_burst,
    // results for the testbench top
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked,
    output int                             o_grants,
    output int                             o_rejects,
    output int                             o_empties
);

    localparam int DEPTH = tcwpd_pkg::QUEUE_DEPTH_DEF;

    typedef struct packed {
        logic [tcwpd_pkg::STATUS_W-1:0] status;
        logic [tcwpd_pkg::TASK_W-1:0]   task_id;
        logic [tcwpd_pkg::CLASS_W-1:0]  cls;
        logic                           waiting;
    } t_dispatch_result;

    // shadow copy of the dispatcher state
    logic [tcwpd_pkg::TASK_W-1:0]   high_q[$];
    logic [tcwpd_pkg::TASK_W-1:0]   normal_q[$];
    logic [tcwpd_pkg::TASK_W-1:0]   low_q[$];
    logic [tcwpd_pkg::CREDIT_W-1:0] high_credit;
    logic [tcwpd_pkg::CREDIT_W-1:0] burst_limit;

    // results still owed by the block, oldest first
    t_dispatch_result               owed_results[$];

    // one transaction through the shadow dispatcher
    function automatic t_dispatch_result dispatch_predict(
        logic kind, logic [tcwpd_pkg::CLASS_W-1:0] prio, logic [tcwpd_pkg::TASK_W-1:0] id
    );
        t_dispatch_result r;
        r = '0;
        if (kind == tcwpd_pkg::KIND_ENQ) begin
            r.status = tcwpd_pkg::ST_FULL;
            case (prio)
                tcwpd_pkg::CLS_LOW: begin
                    if (low_q.size() < DEPTH) begin
                        low_q = {low_q, id};
                        r.status = tcwpd_pkg::ST_ENQUEUED;
                    end
                end
                tcwpd_pkg::CLS_NORMAL: begin
                    if (normal_q.size() < DEPTH) begin
                        normal_q = {normal_q, id};
                        r.status = tcwpd_pkg::ST_ENQUEUED;
                    end
                end
                tcwpd_pkg::CLS_HIGH: begin
                    if (high_q.size() < DEPTH) begin
                        high_q = {high_q, id};
                        r.status = tcwpd_pkg::ST_ENQUEUED;
                    end
                end
                default: ;
            endcase
        end else if (high_q.size() == 0 && normal_q.size() == 0) begin
            // low only when both upper classes are empty
            if (low_q.size() == 0) begin
                r.status = tcwpd_pkg::ST_EMPTY;
            end else begin
                r.status  = tcwpd_pkg::ST_GRANTED;
                r.task_id = low_q.pop_front();
                r.cls     = tcwpd_pkg::CLS_LOW;
            end
        end else if (high_q.size() != 0 &&
                     (normal_q.size() == 0 || high_credit < burst_limit)) begin
            r.status  = tcwpd_pkg::ST_GRANTED;
            r.task_id = high_q.pop_front();
            r.cls     = tcwpd_pkg::CLS_HIGH;
            if (high_credit != tcwpd_pkg::CREDIT_MAX)
                high_credit = high_credit + tcwpd_pkg::CREDIT_W'(1);
        end else begin
            // normal grant pays back the burst, floored at zero
            r.status  = tcwpd_pkg::ST_GRANTED;
            r.task_id = normal_q.pop_front();
            r.cls     = tcwpd_pkg::CLS_NORMAL;
            high_credit = (high_credit >= burst_limit) ? high_credit - burst_limit : '0;
        end
        r.waiting = (high_q.size() != 0) || (normal_q.size() != 0) || (low_q.size() != 0);
        return r;
    endfunction

    function automatic bit field_differs(string name, logic [tcwpd_pkg::TASK_W-1:0] want,
                                         logic [tcwpd_pkg::TASK_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // watch both channels and the config port
    always @(posedge i_clk) begin
        t_dispatch_result want;
        t_dispatch_result pred;
        bit               bad;
        if (!i_rst_n) begin
            high_q.delete();
            normal_q.delete();
            low_q.delete();
            owed_results.delete();
            high_credit = '0;
            burst_limit = tcwpd_pkg::BURST_RESET;
            o_pending   = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                burst_limit = i_cfg_high_burst;

            // compare a delivered result with the oldest one owed
            if (i_out_valid && !i_out_stall) begin
                if (owed_results.size() == 0) begin
                    $display("%0t: unexpected result, status %0h task %0h", $time,
                             i_status, i_granted_task);
                    o_fail_count++;
                end else begin
                    want = owed_results.pop_front();
                    bad  = field_differs("status", tcwpd_pkg::TASK_W'(want.status),
                                         tcwpd_pkg::TASK_W'(i_status));
                    bad |= field_differs("granted_task", want.task_id, i_granted_task);
                    bad |= field_differs("granted_class", tcwpd_pkg::TASK_W'(want.cls),
                                         tcwpd_pkg::TASK_W'(i_granted_class));
                    bad |= field_differs("any_waiting", tcwpd_pkg::TASK_W'(want.waiting),
                                         tcwpd_pkg::TASK_W'(i_any_waiting));
                    if (bad)
                        o_fail_count++;
                    o_checked++;
                    case (want.status)
                        tcwpd_pkg::ST_GRANTED: o_grants++;
                        tcwpd_pkg::ST_FULL:    o_rejects++;
                        tcwpd_pkg::ST_EMPTY:   o_empties++;
                        default:               ;
                    endcase
                end
            end

            if (i_in_valid && !i_in_stall) begin
                pred         = dispatch_predict(i_kind, i_priority_req, i_task_id);
                owed_results = {owed_results, pred};
            end
            o_pending = owed_results.size();
        end
    end

endmodule

// ===== verif/tb_three_class_weighted_priority_dispatch_top.sv =====
`timescale 1ns / 1ps

module tb_three_class_weighted_priority_dispatch_top;

    localparam logic [tcwpd_pkg::CLASS_W-1:0] CLS_UNKNOWN = 2'd3;

    // receiver stall patterns
    localparam int STALL_NONE     = 0;
    localparam int STALL_SPARSE   = 1;
    localparam int STALL_PERIODIC = 2;
    localparam int STALL_HEAVY    = 3;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    logic                           kind;
    logic [tcwpd_pkg::CLASS_W-1:0]  prio;
    logic [tcwpd_pkg::TASK_W-1:0]   task_id;
    logic                           out_valid;
    logic                           out_stall;
    logic [tcwpd_pkg::STATUS_W-1:0] status;
    logic [tcwpd_pkg::TASK_W-1:0]   granted_task;
    logic [tcwpd_pkg::CLASS_W-1:0]  granted_class;
    logic                           any_waiting;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [tcwpd_pkg::CREDIT_W-1:0] cfg_burst;

    int fail_count;
    int pending;
    int checked;
    int grants;
    int rejects;
    int empties;
    int stall_mode;
    int stall_phase;
    logic [tcwpd_pkg::CREDIT_W-1:0] mid_burst;

    three_class_weighted_priority_dispatch_top i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_kind           (kind),
        .i_priority_req   (prio),
        .i_task_id        (task_id),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_status         (status),
        .o_granted_task   (granted_task),
        .o_granted_class  (granted_class),
        .o_any_waiting    (any_waiting),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_high_burst (cfg_burst)
    );

    tcwpd_dispatch_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_kind           (kind),
        .i_priority_req   (prio),
        .i_task_id        (task_id),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_status         (status),
        .i_granted_task   (granted_task),
        .i_granted_class  (granted_class),
        .i_any_waiting    (any_waiting),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_high_burst (cfg_burst),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_checked        (checked),
        .o_grants         (grants),
        .o_rejects        (rejects),
        .o_empties        (empties)
    );

    // 4 ns clock
    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // receiver back-pressure
    always @(posedge clk) begin
        stall_phase <= (stall_phase + 1) % 7;
        case (stall_mode)
            STALL_SPARSE:   out_stall <= ($urandom_range(0, 3) == 0);
            STALL_PERIODIC: out_stall <= (stall_phase < 3);
            STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
            default:        out_stall <= 1'b0;
        endcase
    end

    // hold one transaction until the block takes it
    task automatic send_item(logic k, logic [tcwpd_pkg::CLASS_W-1:0] c,
                             logic [tcwpd_pkg::TASK_W-1:0] id);
        in_valid <= 1'b1;
        kind     <= k;
        prio     <= c;
        task_id  <= id;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic idle_gap(int cycles);
        if (cycles > 0) begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // burst register is only touched once every result is back
    task automatic write_burst(logic [tcwpd_pkg::CREDIT_W-1:0] value);
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_burst <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // random traffic swinging between filling and draining the queues
    task automatic run_phase(int n_items, int high_pct, int mode);
        int                             burst_left;
        int                             sway_left;
        int                             enq_pct;
        int                             pick;
        logic                           k;
        logic [tcwpd_pkg::CLASS_W-1:0]  c;
        logic [tcwpd_pkg::TASK_W-1:0]   id;
        stall_mode = mode;
        burst_left = $urandom_range(1, 30);
        sway_left  = 0;
        enq_pct    = 35;
        for (int i = 0; i < n_items; i++) begin
            if (sway_left == 0) begin
                sway_left = $urandom_range(16, 40);
                enq_pct   = (enq_pct > 50) ? 35 : 70;
            end
            sway_left--;
            k    = ($urandom_range(0, 99) < enq_pct) ? tcwpd_pkg::KIND_ENQ
                                                      : tcwpd_pkg::KIND_DEQ;
            pick = $urandom_range(0, 99);
            if (pick < 5)
                c = CLS_UNKNOWN;
            else if (pick < 5 + high_pct)
                c = tcwpd_pkg::CLS_HIGH;
            else if ($urandom_range(0, 4) < 3)
                c = tcwpd_pkg::CLS_NORMAL;
            else
                c = tcwpd_pkg::CLS_LOW;
            case ($urandom_range(0, 15))
                0:       id = '0;
                1:       id = '1;
                default: id = tcwpd_pkg::TASK_W'($urandom_range(0, 65535));
            endcase
            send_item(k, c, id);
            burst_left--;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 30);
                idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
            end
        end
    endtask

    initial begin
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        kind        <= tcwpd_pkg::KIND_ENQ;
        prio        <= tcwpd_pkg::CLS_LOW;
        task_id     <= '0;
        out_stall   <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_burst   <= tcwpd_pkg::BURST_RESET;
        stall_mode  = STALL_NONE;
        stall_phase = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty dispatch, bad class, id extremes, floor on credit
        stall_mode = STALL_SPARSE;
        send_item(tcwpd_pkg::KIND_DEQ, tcwpd_pkg::CLS_HIGH, 16'h1234);
        send_item(tcwpd_pkg::KIND_ENQ, CLS_UNKNOWN, 16'h1234);
        send_item(tcwpd_pkg::KIND_ENQ, tcwpd_pkg::CLS_LOW, 16'hFFFF);
        send_item(tcwpd_pkg::KIND_ENQ, tcwpd_pkg::CLS_NORMAL, 16'h0000);
        send_item(tcwpd_pkg::KIND_DEQ, CLS_UNKNOWN, 16'hFFFF);
        send_item(tcwpd_pkg::KIND_DEQ, tcwpd_pkg::CLS_LOW, 16'h0000);
        send_item(tcwpd_pkg::KIND_DEQ, tcwpd_pkg::CLS_NORMAL, 16'h8001);
        // fill the high queue and push once more into the full queue
        for (int i = 0; i <= tcwpd_pkg::QUEUE_DEPTH_DEF; i++)
            send_item(tcwpd_pkg::KIND_ENQ, tcwpd_pkg::CLS_HIGH,
                      tcwpd_pkg::TASK_W'((i % 2 == 0) ? 16'hA5A5 ^ i : 16'h5A5A ^ i));

        // burst of zero: high only behind an empty normal queue
        write_burst(8'd0);
        run_phase(300, 60, STALL_NONE);
        write_burst(8'd255);
        run_phase(150, 40, STALL_PERIODIC);
        write_burst(8'd1);
        run_phase(150, 35, STALL_HEAVY);
        mid_burst = tcwpd_pkg::CREDIT_W'($urandom_range(2, 254));
        write_burst(mid_burst);
        run_phase(150, 35, STALL_SPARSE);

        // drain and let the pipeline settle
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (8) @(posedge clk);

        $display("checked %0d results: %0d grants, %0d rejected enqueues, %0d empty dispatches",
                 checked, grants, rejects, empties);
        $display("burst settings 3, 0, 255, 1 and %0d under four stall patterns", mid_burst);
        if (fail_count == 0 && pending == 0)
            $display("[three_class_weighted_priority_dispatch_top] OK");
        else
            $display("[three_class_weighted_priority_dispatch_top] ERROR");
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", pending);
        $display("[three_class_weighted_priority_dispatch_top] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
src/tcwpd_pkg.sv
src/three_class_weighted_priority_dispatch_top.sv
verif/tcwpd_dispatch_checker.sv
verif/tb_three_class_weighted_priority_dispatch_top.sv
